FILE: rtl/core/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg: shared definitions for the MIPS32 instruction execute unit
// Opcode and function codes, data memory geometry and unit command types.
// ----------------------------------------------------------------------------
package mie_pkg;

  // data memory geometry
  localparam int unsigned DATA_BYTES = 4096;
  localparam int unsigned DMEM_AW    = $clog2(DATA_BYTES);

  // primary opcodes
  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  // special function codes
  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;

  // register holding the syscall service code, and the exit service
  localparam logic [4:0]  REG_V0    = 5'd2;
  localparam logic [31:0] SVC_EXIT  = 32'h0000_000A;

  // reset values of the configuration registers
  localparam logic [31:0] TEXT_BASE_RST = 32'h0040_0000;
  localparam logic [31:0] DATA_BASE_RST = 32'h1001_0000;

  // configuration register indexes
  localparam logic CFG_TEXT_BASE = 1'b0;
  localparam logic CFG_DATA_BASE = 1'b1;

  // multiply/divide command
  typedef struct packed {
    logic start;
    logic div;
    logic sgn;
  } md_cmd_t;

endpackage

FILE: rtl/core/mips32_instruction_execute_unit.sv
// ----------------------------------------------------------------------------
// mips32_instruction_execute_unit: MIPS32 integer instruction executor
// Sequence: ALU, shift, HI/LO and syscall instructions pass through three
//   register file reads (rs, rt, v0), execute and retire; multiply and
//   divide also wait on the shared iterative unit; loads and stores visit
//   one data memory byte per cycle, loads with a final read-data wait state.
// Flow: one instruction at a time; a halted unit skips from accept to retire.
// Reset: synchronous; the data memory is cleared after reset and no
//   instruction is accepted until it finishes.
// ----------------------------------------------------------------------------
module mips32_instruction_execute_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_instruction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_next_pc,
  output logic        out_reg_write,
  output logic [4:0]  out_reg_index,
  output logic [31:0] out_reg_value,
  output logic [31:0] out_hi_value,
  output logic [31:0] out_lo_value,
  output logic        out_mem_write,
  output logic [31:0] out_mem_address,
  output logic [31:0] out_mem_value,
  output logic        out_div_by_zero,
  output logic        out_halted
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RS   = 4'd1;
  localparam logic [3:0] S_RT   = 4'd2;
  localparam logic [3:0] S_R2   = 4'd3;
  localparam logic [3:0] S_EXEC = 4'd4;
  localparam logic [3:0] S_MD   = 4'd5;
  localparam logic [3:0] S_MEM  = 4'd6;
  localparam logic [3:0] S_MEMD = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0]  state_r;
  logic [31:0] instr_r;
  logic [31:0] pc_r;
  logic [31:0] data_base_r;
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic        halted_r;
  logic [31:0] a_r;
  logic [31:0] b_r;

  // per-transaction results
  logic        skip_r;
  logic        wr_r;
  logic [4:0]  widx_r;
  logic [31:0] wval_r;
  logic        mw_r;
  logic [31:0] maddr_r;
  logic [31:0] mval_r;
  logic        dz_r;
  logic        is_store_r;
  logic [1:0]  nb_r;
  logic [1:0]  bi_r;
  logic [31:0] ld_r;
  logic        pend_v_r;
  logic [1:0]  pend_idx_r;
  logic        pend_win_r;

  // output register
  logic        out_valid_r;
  logic [31:0] out_pc_r;
  logic        out_wr_r;
  logic [4:0]  out_idx_r;
  logic [31:0] out_val_r;
  logic [31:0] out_hi_r;
  logic [31:0] out_lo_r;
  logic        out_mw_r;
  logic [31:0] out_maddr_r;
  logic [31:0] out_mval_r;
  logic        out_dz_r;
  logic        out_halt_r;

  // instruction fields
  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [31:0] imm;
  logic [31:0] simm;

  assign op   = instr_r[31:26];
  assign rs   = instr_r[25:21];
  assign rt   = instr_r[20:16];
  assign rd   = instr_r[15:11];
  assign sa   = instr_r[10:6];
  assign fn   = instr_r[5:0];
  assign imm  = {16'h0, instr_r[15:0]};
  assign simm = {{16{instr_r[15]}}, instr_r[15:0]};

  // submodule wiring
  logic [4:0]                  rf_raddr;
  logic [31:0]                 rf_rdata;
  logic                        rf_we;
  logic [4:0]                  rf_waddr;
  logic [31:0]                 rf_wdata;
  logic                        dm_busy;
  logic [mie_pkg::DMEM_AW-1:0] dm_raddr;
  logic [7:0]                  dm_rdata;
  logic                        dm_we;
  logic [7:0]                  dm_wdata;
  mie_pkg::md_cmd_t            md_cmd;
  logic                        md_done;
  logic [31:0]                 md_hi;
  logic [31:0]                 md_lo;

  // execute decode
  logic        ex_wr;
  logic [4:0]  ex_idx;
  logic [31:0] ex_val;
  logic        ex_mem;
  logic        ex_store;
  logic [1:0]  ex_nb;
  logic        ex_md;
  logic        ex_div;
  logic        ex_sgn;
  logic [31:0] ex_ea;
  logic [31:0] ex_mval;

  assign ex_ea = a_r + simm;

  always_comb begin
    ex_wr    = 1'b0;
    ex_idx   = rd;
    ex_val   = 32'h0;
    ex_mem   = 1'b0;
    ex_store = 1'b0;
    ex_nb    = 2'd0;
    ex_md    = 1'b0;
    ex_div   = 1'b0;
    ex_sgn   = 1'b0;
    ex_mval  = 32'h0;
    if (op == mie_pkg::OP_SPECIAL) begin
      unique case (fn) inside
        mie_pkg::FN_SLL: begin ex_wr = 1'b1; ex_val = b_r << sa; end
        mie_pkg::FN_SRL: begin ex_wr = 1'b1; ex_val = b_r >> sa; end
        mie_pkg::FN_SRA: begin ex_wr = 1'b1; ex_val = $unsigned($signed(b_r) >>> sa); end
        mie_pkg::FN_MFHI: begin ex_wr = 1'b1; ex_val = hi_r; end
        mie_pkg::FN_MFLO: begin ex_wr = 1'b1; ex_val = lo_r; end
        mie_pkg::FN_MULT: begin ex_md = 1'b1; ex_sgn = 1'b1; end
        mie_pkg::FN_MULTU: begin ex_md = 1'b1; end
        mie_pkg::FN_DIV: begin ex_md = 1'b1; ex_div = 1'b1; ex_sgn = 1'b1; end
        mie_pkg::FN_DIVU: begin ex_md = 1'b1; ex_div = 1'b1; end
        mie_pkg::FN_ADD, mie_pkg::FN_ADDU: begin ex_wr = 1'b1; ex_val = a_r + b_r; end
        mie_pkg::FN_SUB, mie_pkg::FN_SUBU: begin ex_wr = 1'b1; ex_val = a_r - b_r; end
        mie_pkg::FN_AND: begin ex_wr = 1'b1; ex_val = a_r & b_r; end
        mie_pkg::FN_OR:  begin ex_wr = 1'b1; ex_val = a_r | b_r; end
        mie_pkg::FN_XOR: begin ex_wr = 1'b1; ex_val = a_r ^ b_r; end
        mie_pkg::FN_NOR: begin ex_wr = 1'b1; ex_val = ~(a_r | b_r); end
        mie_pkg::FN_SLT: begin
          ex_wr  = 1'b1;
          ex_val = {31'h0, $signed(a_r) < $signed(b_r)};
        end
        default: ex_wr = 1'b0;
      endcase
    end else begin
      ex_idx = rt;
      unique case (op) inside
        mie_pkg::OP_ADDI, mie_pkg::OP_ADDIU: begin ex_wr = 1'b1; ex_val = a_r + simm; end
        mie_pkg::OP_SLTI: begin
          ex_wr  = 1'b1;
          ex_val = {31'h0, $signed(a_r) < $signed(simm)};
        end
        mie_pkg::OP_ANDI: begin ex_wr = 1'b1; ex_val = a_r & imm; end
        mie_pkg::OP_ORI:  begin ex_wr = 1'b1; ex_val = a_r | imm; end
        mie_pkg::OP_XORI: begin ex_wr = 1'b1; ex_val = a_r ^ imm; end
        mie_pkg::OP_LUI:  begin ex_wr = 1'b1; ex_val = {instr_r[15:0], 16'h0}; end
        mie_pkg::OP_LB: begin ex_wr = 1'b1; ex_mem = 1'b1; ex_nb = 2'd0; end
        mie_pkg::OP_LH: begin ex_wr = 1'b1; ex_mem = 1'b1; ex_nb = 2'd1; end
        mie_pkg::OP_LW: begin ex_wr = 1'b1; ex_mem = 1'b1; ex_nb = 2'd3; end
        mie_pkg::OP_SB: begin
          ex_mem = 1'b1; ex_store = 1'b1; ex_nb = 2'd0; ex_mval = {24'h0, b_r[7:0]};
        end
        mie_pkg::OP_SH: begin
          ex_mem = 1'b1; ex_store = 1'b1; ex_nb = 2'd1; ex_mval = {16'h0, b_r[15:0]};
        end
        mie_pkg::OP_SW: begin
          ex_mem = 1'b1; ex_store = 1'b1; ex_nb = 2'd3; ex_mval = b_r;
        end
        default: ex_wr = 1'b0;
      endcase
    end
  end

  // byte window check for the current memory byte
  logic [31:0] mem_off;
  logic        mem_win;

  assign mem_off = maddr_r + {30'h0, bi_r} - data_base_r;
  assign mem_win = {1'b0, mem_off} < 33'(mie_pkg::DATA_BYTES);

  // load value extension at retire
  logic [31:0] fin_val;
  logic        fin_wr;
  logic        out_free;

  always_comb begin
    unique case (op)
      mie_pkg::OP_LB: fin_val = {{24{ld_r[7]}}, ld_r[7:0]};
      mie_pkg::OP_LH: fin_val = {{16{ld_r[15]}}, ld_r[15:0]};
      mie_pkg::OP_LW: fin_val = ld_r;
      default:        fin_val = wval_r;
    endcase
  end

  assign fin_wr   = wr_r && (widx_r != 5'd0) && !skip_r;
  assign out_free = !out_valid_r || out_ready;

  // register file port selection
  always_comb begin
    unique case (state_r)
      S_RS:    rf_raddr = rs;
      S_RT:    rf_raddr = rt;
      default: rf_raddr = mie_pkg::REG_V0;
    endcase
  end

  assign rf_we    = (state_r == S_FIN) && out_free && fin_wr;
  assign rf_waddr = widx_r;
  assign rf_wdata = fin_val;

  assign dm_raddr = mem_off[mie_pkg::DMEM_AW-1:0];
  assign dm_we    = (state_r == S_MEM) && is_store_r && mem_win;
  assign dm_wdata = mval_r[{bi_r, 3'b000} +: 8];

  assign md_cmd.start = (state_r == S_EXEC) && ex_md && !(ex_div && b_r == 32'h0);
  assign md_cmd.div   = ex_div;
  assign md_cmd.sgn   = ex_sgn;

  mie_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .raddr (rf_raddr),
    .rdata (rf_rdata),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata)
  );

  mie_dmem u_dmem (
    .clk   (clk),
    .rst_n (rst_n),
    .busy  (dm_busy),
    .raddr (dm_raddr),
    .rdata (dm_rdata),
    .we    (dm_we),
    .waddr (dm_raddr),
    .wdata (dm_wdata)
  );

  mie_muldiv u_muldiv (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (md_cmd),
    .a    (a_r),
    .b    (b_r),
    .done (md_done),
    .hi   (md_hi),
    .lo   (md_lo)
  );

  assign in_ready = (state_r == S_IDLE) && !dm_busy;

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= mie_pkg::TEXT_BASE_RST;
      data_base_r <= mie_pkg::DATA_BASE_RST;
      hi_r        <= 32'h0;
      lo_r        <= 32'h0;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pend_v_r    <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      // configuration writes
      if (cfg_we) begin
        if (cfg_index == mie_pkg::CFG_TEXT_BASE) begin
          pc_r <= cfg_wdata;
        end else begin
          data_base_r <= cfg_wdata;
        end
      end
      // merge a returning load byte
      pend_v_r <= 1'b0;
      if (pend_v_r && pend_win_r) begin
        ld_r[{pend_idx_r, 3'b000} +: 8] <= dm_rdata;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            instr_r <= in_instruction;
            skip_r  <= halted_r;
            wr_r    <= 1'b0;
            widx_r  <= 5'd0;
            wval_r  <= 32'h0;
            mw_r    <= 1'b0;
            maddr_r <= 32'h0;
            mval_r  <= 32'h0;
            dz_r    <= 1'b0;
            ld_r    <= 32'h0;
            state_r <= halted_r ? S_FIN : S_RS;
          end
        end
        S_RS: state_r <= S_RT;
        S_RT: begin
          a_r     <= rf_rdata;
          state_r <= S_R2;
        end
        S_R2: begin
          b_r     <= rf_rdata;
          state_r <= S_EXEC;
        end
        S_EXEC: begin
          wr_r    <= ex_wr;
          widx_r  <= ex_idx;
          wval_r  <= ex_val;
          state_r <= S_FIN;
          if (op == mie_pkg::OP_SPECIAL && fn == mie_pkg::FN_SYSCALL
              && rf_rdata == mie_pkg::SVC_EXIT) begin
            halted_r <= 1'b1;
          end
          if (op == mie_pkg::OP_SPECIAL && fn == mie_pkg::FN_MTHI) begin
            hi_r <= a_r;
          end
          if (op == mie_pkg::OP_SPECIAL && fn == mie_pkg::FN_MTLO) begin
            lo_r <= a_r;
          end
          if (ex_md) begin
            if (ex_div && b_r == 32'h0) begin
              dz_r <= 1'b1;
            end else begin
              state_r <= S_MD;
            end
          end
          if (ex_mem) begin
            maddr_r    <= ex_ea;
            mval_r     <= ex_mval;
            is_store_r <= ex_store;
            nb_r       <= ex_nb;
            bi_r       <= 2'd0;
            state_r    <= S_MEM;
          end
        end
        S_MD: begin
          if (md_done) begin
            hi_r    <= md_hi;
            lo_r    <= md_lo;
            state_r <= S_FIN;
          end
        end
        S_MEM: begin
          if (is_store_r) begin
            mw_r <= mw_r | mem_win;
          end else begin
            pend_v_r   <= 1'b1;
            pend_idx_r <= bi_r;
            pend_win_r <= mem_win;
          end
          bi_r <= bi_r + 1'b1;
          if (bi_r == nb_r) begin
            state_r <= is_store_r ? S_FIN : S_MEMD;
          end
        end
        S_MEMD: state_r <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= skip_r ? pc_r : pc_r + 32'd4;
            out_wr_r    <= fin_wr;
            out_idx_r   <= fin_wr ? widx_r : 5'd0;
            out_val_r   <= fin_wr ? fin_val : 32'h0;
            out_hi_r    <= hi_r;
            out_lo_r    <= lo_r;
            out_mw_r    <= mw_r;
            out_maddr_r <= maddr_r;
            out_mval_r  <= mval_r;
            out_dz_r    <= dz_r;
            out_halt_r  <= halted_r;
            if (!skip_r) begin
              pc_r <= pc_r + 32'd4;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_next_pc     = out_pc_r;
  assign out_reg_write   = out_wr_r;
  assign out_reg_index   = out_idx_r;
  assign out_reg_value   = out_val_r;
  assign out_hi_value    = out_hi_r;
  assign out_lo_value    = out_lo_r;
  assign out_mem_write   = out_mw_r;
  assign out_mem_address = out_maddr_r;
  assign out_mem_value   = out_mval_r;
  assign out_div_by_zero = out_dz_r;
  assign out_halted      = out_halt_r;

endmodule

FILE: rtl/core/mie_regfile.sv
// ----------------------------------------------------------------------------
// mie_regfile: general register file
// 32 x 32 storage, one registered read port, one write port; per-entry valid
// bits make unwritten entries read as zero right after reset.
// ----------------------------------------------------------------------------
module mie_regfile (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [4:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [4:0]  waddr,
  input  logic [31:0] wdata
);

  logic [31:0] mem [32];
  logic [31:0] vld_r;
  logic [31:0] rdata_r;

  // track written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  // write storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, zero for entries never written
  always_ff @(posedge clk) begin
    rdata_r <= vld_r[raddr] ? mem[raddr] : 32'h0;
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mie_dmem.sv
// ----------------------------------------------------------------------------
// mie_dmem: byte-wide data memory
// One write and one registered read per cycle; a clearing pass after reset
// zeroes every byte, one per cycle, while busy is high.
// ----------------------------------------------------------------------------
module mie_dmem (
  input  logic                        clk,
  input  logic                        rst_n,
  output logic                        busy,
  input  logic [mie_pkg::DMEM_AW-1:0] raddr,
  output logic [7:0]                  rdata,
  input  logic                        we,
  input  logic [mie_pkg::DMEM_AW-1:0] waddr,
  input  logic [7:0]                  wdata
);

  logic [7:0]                  mem [mie_pkg::DATA_BYTES];
  logic [7:0]                  rdata_r;
  logic                        busy_r;
  logic [mie_pkg::DMEM_AW-1:0] clr_r;

  // sweep clear pointer after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      clr_r  <= '0;
    end else if (busy_r) begin
      clr_r <= clr_r + 1'b1;
      if (&clr_r) begin
        busy_r <= 1'b0;
      end
    end
  end

  // write port, clearing has priority
  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_r] <= 8'h00;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign busy  = busy_r;
  assign rdata = rdata_r;

endmodule

FILE: rtl/core/mie_muldiv.sv
// ----------------------------------------------------------------------------
// mie_muldiv: iterative multiply/divide unit
// Radix-2 shift-add multiply and restoring divide on magnitudes, 32 steps,
// followed by a sign correction step.
// ----------------------------------------------------------------------------
module mie_muldiv (
  input  logic             clk,
  input  logic             rst_n,
  input  mie_pkg::md_cmd_t cmd,
  input  logic [31:0]      a,
  input  logic [31:0]      b,
  output logic             done,
  output logic [31:0]      hi,
  output logic [31:0]      lo
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0]  state_r;
  logic [4:0]  cnt_r;
  logic        div_r;
  logic        neg_q_r;
  logic        neg_r_r;
  logic        done_r;
  logic [31:0] hi_r;
  logic [31:0] lo_r;
  logic [31:0] opb_r;

  logic [31:0] ma;
  logic [31:0] mb;
  logic [32:0] mul_sum;
  logic [32:0] rem_sh;
  logic [32:0] rem_diff;
  logic        rem_ge;
  logic [63:0] prod_neg;

  // operand magnitudes
  assign ma = (cmd.sgn && a[31]) ? (32'h0 - a) : a;
  assign mb = (cmd.sgn && b[31]) ? (32'h0 - b) : b;

  // one step of each algorithm
  assign mul_sum  = {1'b0, hi_r} + (lo_r[0] ? {1'b0, opb_r} : 33'h0);
  assign rem_sh   = {hi_r, lo_r[31]};
  assign rem_diff = rem_sh - {1'b0, opb_r};
  assign rem_ge   = rem_sh >= {1'b0, opb_r};
  assign prod_neg = 64'h0 - {hi_r, lo_r};

  // sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (&cnt_r) begin
            state_r <= S_FIX;
          end
        end
        S_FIX: begin
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd.start) begin
      div_r   <= cmd.div;
      hi_r    <= 32'h0;
      lo_r    <= ma;
      opb_r   <= mb;
      neg_q_r <= cmd.sgn && (a[31] != b[31]);
      neg_r_r <= cmd.sgn && a[31];
    end else if (state_r == S_RUN) begin
      if (div_r) begin
        hi_r <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
        lo_r <= {lo_r[30:0], rem_ge};
      end else begin
        hi_r <= mul_sum[32:1];
        lo_r <= {mul_sum[0], lo_r[31:1]};
      end
    end else if (state_r == S_FIX) begin
      if (div_r) begin
        if (neg_q_r) begin
          lo_r <= 32'h0 - lo_r;
        end
        if (neg_r_r) begin
          hi_r <= 32'h0 - hi_r;
        end
      end else if (neg_q_r) begin
        hi_r <= prod_neg[63:32];
        lo_r <= prod_neg[31:0];
      end
    end
  end

  assign done = done_r;
  assign hi   = hi_r;
  assign lo   = lo_r;

endmodule

FILE: rtl/core/mie_checker.sv
// ----------------------------------------------------------------------------
// mie_checker: port-level checks for the instruction execute unit
// Watches the top-level ports and flags result transactions that break
// the unit's output rules.
// ----------------------------------------------------------------------------
module mie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_next_pc,
  input logic        out_reg_write,
  input logic [4:0]  out_reg_index,
  input logic [31:0] out_reg_value,
  input logic        out_mem_write,
  input logic        out_halted
);

  // a stalled result stays valid with a stable next PC
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_next_pc))
    else $error("result changed while stalled");

  // r0 is never reported as written
  a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reg_write |-> out_reg_index != 5'd0)
    else $error("write to r0 reported");

  // unused register fields read zero
  a_idle_reg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reg_write |-> out_reg_index == 5'd0 && out_reg_value == 32'h0)
    else $error("register fields set without a write");

  // halted results change nothing
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_reg_write && !out_mem_write)
    else $error("halted result reports a write");

  // one transaction in flight
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on consecutive cycles");

endmodule

bind mips32_instruction_execute_unit mie_checker u_mie_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_next_pc   (out_next_pc),
  .out_reg_write (out_reg_write),
  .out_reg_index (out_reg_index),
  .out_reg_value (out_reg_value),
  .out_mem_write (out_mem_write),
  .out_halted    (out_halted)
);
